// ===== hw/rtl/cfr_pkg.sv =====
// Shared types, codes and the CRC-16/CCITT byte step for the frame receiver.
package cfr_pkg;

    // APB address width: seven 32-bit registers at byte address 4*i
    localparam int unsigned AddrW = 5;

    // Register indexes, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_SYNC_FIRST  = 3'd0,
        REG_SYNC_SECOND = 3'd1,
        REG_CODE_BEGIN  = 3'd2,
        REG_CODE_CHUNK  = 3'd3,
        REG_CODE_FINISH = 3'd4,
        REG_CODE_PING   = 3'd5,
        REG_MAX_PAYLOAD = 3'd6
    } t_reg_idx;

    // Reset values of the registers
    localparam logic [7:0]  SyncFirstRst  = 8'hEB;
    localparam logic [7:0]  SyncSecondRst = 8'h00;
    localparam logic [7:0]  CodeBeginRst  = 8'd1;
    localparam logic [7:0]  CodeChunkRst  = 8'd2;
    localparam logic [7:0]  CodeFinishRst = 8'd3;
    localparam logic [7:0]  CodePingRst   = 8'd4;
    localparam logic [15:0] MaxPayloadRst = 16'd4096;

    localparam logic [15:0] CrcPoly = 16'h1021;
    localparam logic [15:0] CrcInit = 16'h0000;

    // Frame parser phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SYNC = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CRC  = 3'd5
    } t_phase;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_GOOD    = 3'd2,
        EV_CRC_BAD = 3'd3,
        EV_BAD_CMD = 3'd4,
        EV_BAD_LEN = 3'd5
    } t_event;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  code_begin;
        logic [7:0]  code_chunk;
        logic [7:0]  code_finish;
        logic [7:0]  code_ping;
        logic [15:0] max_payload;
    } t_cfg;

    // One queued received byte with its classification
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_sync_first;
        logic       is_sync_second;
        logic       is_code;
    } t_qent;

    // Front-to-back queue head
    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qhead;

    // One result beat
    typedef struct packed {
        t_event      event_res;
        logic [7:0]  frame_command;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        nak_valid;
        logic [15:0] nak_index;
    } t_result;

    // CRC-16/CCITT, MSB first, one byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/cfr_in_if.sv =====
// Received-byte channel: valid/ready handshake with one byte per beat.
interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/cfr_out_if.sv =====
// Result channel: valid/ready handshake with one result per beat.
interface cfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  frame_command;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        nak_valid;
    logic [15:0] nak_index;

    modport source (
        output valid, output event_res, output frame_command, output frame_length,
        output payload_byte, output payload_index, output nak_valid, output nak_index,
        input ready
    );
    modport sink (
        input valid, input event_res, input frame_command, input frame_length,
        input payload_byte, input payload_index, input nak_valid, input nak_index,
        output ready
    );
endinterface

// ===== hw/rtl/cfr_regs.sv =====
// APB configuration register file of the frame receiver.
module cfr_regs
    import cfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [AddrW-1:0] i_paddr,
    input  logic [31:0]      i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign idx      = t_reg_idx'(i_paddr[AddrW-1:2]);
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    // register writes in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SyncFirstRst;
            r_cfg.sync_second <= SyncSecondRst;
            r_cfg.code_begin  <= CodeBeginRst;
            r_cfg.code_chunk  <= CodeChunkRst;
            r_cfg.code_finish <= CodeFinishRst;
            r_cfg.code_ping   <= CodePingRst;
            r_cfg.max_payload <= MaxPayloadRst;
        end else if (wr_en) begin
            case (idx)
                REG_SYNC_FIRST:  r_cfg.sync_first  <= i_pwdata[7:0];
                REG_SYNC_SECOND: r_cfg.sync_second <= i_pwdata[7:0];
                REG_CODE_BEGIN:  r_cfg.code_begin  <= i_pwdata[7:0];
                REG_CODE_CHUNK:  r_cfg.code_chunk  <= i_pwdata[7:0];
                REG_CODE_FINISH: r_cfg.code_finish <= i_pwdata[7:0];
                REG_CODE_PING:   r_cfg.code_ping   <= i_pwdata[7:0];
                REG_MAX_PAYLOAD: r_cfg.max_payload <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (idx)
            REG_SYNC_FIRST:  o_prdata = {24'h0, r_cfg.sync_first};
            REG_SYNC_SECOND: o_prdata = {24'h0, r_cfg.sync_second};
            REG_CODE_BEGIN:  o_prdata = {24'h0, r_cfg.code_begin};
            REG_CODE_CHUNK:  o_prdata = {24'h0, r_cfg.code_chunk};
            REG_CODE_FINISH: o_prdata = {24'h0, r_cfg.code_finish};
            REG_CODE_PING:   o_prdata = {24'h0, r_cfg.code_ping};
            REG_MAX_PAYLOAD: o_prdata = {16'h0, r_cfg.max_payload};
            default:         o_prdata = 32'h0;
        endcase
    end

endmodule

// ===== hw/rtl/cfr_front.sv =====
// Front end: accepts received bytes, classifies them and queues them (two entries).
module cfr_front
    import cfr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    cfr_in_if.sink rx,
    input  logic   i_pop,
    output t_qhead o_head
);

    t_qent      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;
    t_qent      cls;

    // classify the incoming byte against the sync word and command codes
    always_comb begin
        cls.rx_byte        = rx.rx_byte;
        cls.is_sync_first  = (rx.rx_byte == i_cfg.sync_first);
        cls.is_sync_second = (rx.rx_byte == i_cfg.sync_second);
        cls.is_code        = (rx.rx_byte == i_cfg.code_begin)  ||
                             (rx.rx_byte == i_cfg.code_chunk)  ||
                             (rx.rx_byte == i_cfg.code_finish) ||
                             (rx.rx_byte == i_cfg.code_ping);
    end

    assign rx.ready     = (r_count != 2'd2);
    assign push         = rx.valid & rx.ready;
    assign pop          = i_pop & (r_count != 2'd0);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.ent   = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/cfr_back.sv =====
// Back end: frame parser, CRC check and the result output register.
module cfr_back
    import cfr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_qhead   i_head,
    output logic     o_pop,
    cfr_out_if.source res
);

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_cmd,     n_cmd;
    logic [31:0] r_len,     n_len;
    logic [15:0] r_pos,     n_pos;
    logic [15:0] r_crc,     n_crc;
    logic [7:0]  r_crc_lo,  n_crc_lo;
    logic        r_crc_half, n_crc_half;
    logic [15:0] r_lead,    n_lead;

    logic        r_out_valid;
    t_result     r_out;
    t_result     nres;
    logic        finish;
    logic [7:0]  b;
    logic [16:0] pos_inc;
    logic [31:0] len_byte;

    assign o_pop   = i_head.valid & (~r_out_valid | res.ready);
    assign b       = i_head.ent.rx_byte;
    assign pos_inc = {1'b0, r_pos} + 17'd1;

    // little-endian lane of the length word
    always_comb begin
        unique case (r_pos[1:0])
            2'd0: len_byte = {24'h0, b};
            2'd1: len_byte = {16'h0, b, 8'h0};
            2'd2: len_byte = {8'h0, b, 16'h0};
            2'd3: len_byte = {b, 24'h0};
        endcase
    end

    // frame parser: next state and result for the byte at the queue head
    always_comb begin
        n_phase    = r_phase;
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_crc_lo   = r_crc_lo;
        n_crc_half = r_crc_half;
        n_lead     = r_lead;
        finish     = 1'b0;
        nres       = '0;
        nres.event_res = EV_NONE;

        unique case (r_phase)
            PH_SYNC: begin
                if (i_head.ent.is_sync_second) begin
                    n_phase = PH_CMD;
                    n_crc   = CrcInit;
                end else if (!i_head.ent.is_sync_first) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CMD: begin
                n_cmd = b;
                if (i_head.ent.is_code) begin
                    n_crc   = crc_update(r_crc, b);
                    n_len   = '0;
                    n_pos   = '0;
                    n_phase = PH_LEN;
                end else begin
                    nres.event_res = EV_BAD_CMD;
                    finish = 1'b1;
                end
            end
            PH_LEN: begin
                n_len = r_len | len_byte;
                n_crc = crc_update(r_crc, b);
                n_pos = pos_inc[15:0];
                if (r_pos[1:0] == 2'd3) begin
                    n_pos = '0;
                    if (n_len > {16'h0, i_cfg.max_payload}) begin
                        nres.event_res = EV_BAD_LEN;
                        finish = 1'b1;
                    end else if (n_len == 32'h0) begin
                        n_phase    = PH_CRC;
                        n_crc_lo   = '0;
                        n_crc_half = 1'b0;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                nres.event_res     = EV_PAYLOAD;
                nres.payload_byte  = b;
                nres.payload_index = r_pos;
                if (r_pos == 16'd0) begin
                    n_lead = {r_lead[15:8], b};
                end else if (r_pos == 16'd1) begin
                    n_lead = {b, r_lead[7:0]};
                end
                n_crc = crc_update(r_crc, b);
                n_pos = pos_inc[15:0];
                if ({15'h0, pos_inc} >= r_len) begin
                    n_phase    = PH_CRC;
                    n_crc_lo   = '0;
                    n_crc_half = 1'b0;
                end
            end
            PH_CRC: begin
                if (!r_crc_half) begin
                    n_crc_lo   = b;
                    n_crc_half = 1'b1;
                end else begin
                    if ({b, r_crc_lo} == r_crc) begin
                        nres.event_res = EV_GOOD;
                    end else begin
                        nres.event_res = EV_CRC_BAD;
                        if ((r_cmd == i_cfg.code_chunk) && (r_len >= 32'd2)) begin
                            nres.nak_valid = 1'b1;
                            nres.nak_index = r_lead;
                        end
                    end
                    finish = 1'b1;
                end
            end
            default: begin
                // hunting, also any unused phase code
                n_phase = i_head.ent.is_sync_first ? PH_SYNC : PH_IDLE;
            end
        endcase

        // the result shows the frame's command and saturated length
        nres.frame_command = n_cmd;
        nres.frame_length  = (n_len[31:16] != 16'h0) ? 16'hFFFF : n_len[15:0];

        if (finish) begin
            n_phase    = PH_IDLE;
            n_cmd      = '0;
            n_len      = '0;
            n_pos      = '0;
            n_crc      = '0;
            n_crc_lo   = '0;
            n_crc_half = 1'b0;
            n_lead     = '0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cmd      <= '0;
            r_len      <= '0;
            r_pos      <= '0;
            r_crc      <= '0;
            r_crc_lo   <= '0;
            r_crc_half <= 1'b0;
            r_lead     <= '0;
        end else if (o_pop) begin
            r_phase    <= n_phase;
            r_cmd      <= n_cmd;
            r_len      <= n_len;
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_crc_lo   <= n_crc_lo;
            r_crc_half <= n_crc_half;
            r_lead     <= n_lead;
        end
    end

    // output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register: payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= nres;
        end
    end

    assign res.valid         = r_out_valid;
    assign res.event_res     = r_out.event_res;
    assign res.frame_command = r_out.frame_command;
    assign res.frame_length  = r_out.frame_length;
    assign res.payload_byte  = r_out.payload_byte;
    assign res.payload_index = r_out.payload_index;
    assign res.nak_valid     = r_out.nak_valid;
    assign res.nak_index     = r_out.nak_index;

endmodule

// ===== hw/rtl/crc_checked_frame_receiver_top.sv =====
// Top level of the CRC-checked frame receiver.
//
//   port        dir  beat / transfer
//   i_rx        in   one received byte (rx_byte)
//   o_res       out  one result per byte (event, command, length, payload, nak)
//   i_p*/o_p*   cfg  APB register writes and reads, register i at byte 4*i
//
// One byte per cycle sustained while o_res is ready: each byte costs one pass of
// the parser and one byte-wide CRC step in the back end, which registers its result.
// The two-entry byte queue lets the input keep flowing while a result waits.
// Synchronous active-low reset returns the parser to sync hunting and the
// registers to their defaults; no clearing pass is needed.
module crc_checked_frame_receiver_top
    import cfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    cfr_in_if.sink           i_rx,
    cfr_out_if.source        o_res,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [AddrW-1:0] i_paddr,
    input  logic [31:0]      i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    t_cfg   cfg;
    t_qhead head;
    logic   pop;

    // configuration registers
    cfr_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // byte intake and classification
    cfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .rx      (i_rx),
        .i_pop   (pop),
        .o_head  (head)
    );

    // frame parsing and result output
    cfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_head  (head),
        .o_pop   (pop),
        .res     (o_res)
    );

endmodule
